>>> hw/rtl/epoch_seconds_to_calendar_date_macros.svh
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// Both macros sample on clk and are switched off while rst_n is low.

// Same-cycle implication.
`define ES2CD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ES2CD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/es2cd_pkg.sv
`timescale 1ns / 1ps

package es2cd_pkg;

    localparam int YEAR_SPAN_DEF = 100;
    localparam int YEAR_CNT_W    = 8;
    localparam int SECS_W        = 32;
    localparam int LEN_W         = 25;

    localparam logic [LEN_W-1:0] DAY_SECS       = LEN_W'(86400);
    localparam logic [LEN_W-1:0] HOUR_SECS      = LEN_W'(3600);
    localparam logic [LEN_W-1:0] MIN_SECS       = LEN_W'(60);
    localparam logic [LEN_W-1:0] YEAR_SECS      = LEN_W'(365 * 86400);
    localparam logic [LEN_W-1:0] YEAR_LEAP_SECS = LEN_W'(366 * 86400);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic       in_range;
        logic [6:0] year_offset;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } es2cd_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } es2cd_status_t;

    // Year offsets from 2000 only reach 2100 with the default YEAR_SPAN, so the only century year that
    // breaks the four-year rule is 2100.
    function automatic logic is_leap(input logic [YEAR_CNT_W-1:0] off);
        return (off[1:0] == 2'b00) && (off != YEAR_CNT_W'(100));
    endfunction

    function automatic logic [LEN_W-1:0] month_secs(input logic [3:0] m, input logic leap);
        logic [LEN_W-1:0] secs;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: secs = LEN_W'(30 * 86400);
            MONTH_FEB:               secs = leap ? LEN_W'(29 * 86400) : LEN_W'(28 * 86400);
            default:                 secs = LEN_W'(31 * 86400);
        endcase
        return secs;
    endfunction

endpackage

>>> hw/rtl/epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps

// Converts a count of seconds since 2000-01-01 00:00:00 into year offset from
// 2000, month, day, hour, minute and second under the Gregorian leap rule.
// Counts at or beyond YEAR_SPAN years give in_range low and all date fields
// zero. One 32-bit subtract-and-compare unit is stepped once a cycle through
// the years, months, days, hours and minutes. A finished item is loaded into
// the output register once that register is free, and the next item can be
// accepted in the cycle after the load. The input side is not ready while a
// conversion runs; a finished item waits in the output register, so the next
// conversion can start before it is taken.
module epoch_seconds_to_calendar_date
    import es2cd_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] seconds_count
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] year_offset, [10:7] month, [15:11] day, [20:16] hour,
    // [26:21] minute, [32:27] second, [39:33] zero
    output logic [39:0] m_axis_tdata,
    // [0] in_range
    output logic        m_axis_tuser
);

    es2cd_status_t status;
    es2cd_result_t result;
    logic          start;
    logic          load;
    logic          out_valid_reg, out_valid_next;
    es2cd_result_t out_reg;

    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid & s_axis_tready;
    assign load          = status.done & (~out_valid_reg | m_axis_tready);

    es2cd_seq #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .seconds_count (s_axis_tdata),
        .load          (load),
        .status        (status),
        .result        (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.in_range;
    assign m_axis_tdata  = {7'd0, out_reg.second, out_reg.minute, out_reg.hour,
                            out_reg.day, out_reg.month, out_reg.year_offset};

endmodule

>>> hw/rtl/es2cd_sub.sv
`timescale 1ns / 1ps

module es2cd_sub
    import es2cd_pkg::*;
(
    input  logic [SECS_W-1:0] rem,
    input  logic [LEN_W-1:0]  len,
    output logic [SECS_W-1:0] diff,
    output logic              ge
);

    logic [SECS_W:0] wide;

    // The borrow out of the subtraction doubles as the compare result.
    assign wide = {1'b0, rem} - {1'b0, SECS_W'(len)};
    assign diff = wide[SECS_W-1:0];
    assign ge   = ~wide[SECS_W];

endmodule

>>> hw/rtl/es2cd_seq.sv
`timescale 1ns / 1ps

`include "epoch_seconds_to_calendar_date_macros.svh"

module es2cd_seq
    import es2cd_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SECS_W-1:0]  seconds_count,
    input  logic               load,
    output es2cd_status_t      status,
    output es2cd_result_t      result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_YEAR  = 3'd1;
    localparam logic [2:0] ST_MONTH = 3'd2;
    localparam logic [2:0] ST_DAY   = 3'd3;
    localparam logic [2:0] ST_HOUR  = 3'd4;
    localparam logic [2:0] ST_MIN   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [YEAR_CNT_W-1:0] SPAN = YEAR_CNT_W'(YEAR_SPAN);

    logic [2:0]            state_reg, state_next;
    logic                  in_range_reg, in_range_next;
    logic [SECS_W-1:0]     rem_reg, rem_next;
    logic [YEAR_CNT_W-1:0] year_reg, year_next;
    logic [3:0]            month_reg, month_next;
    logic [4:0]            day_reg, day_next;
    logic [4:0]            hour_reg, hour_next;
    logic [5:0]            minute_reg, minute_next;

    logic [LEN_W-1:0]      len;
    logic [SECS_W-1:0]     diff;
    logic                  ge;
    logic                  leap;

    assign leap = is_leap(year_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_YEAR:  len = leap ? YEAR_LEAP_SECS : YEAR_SECS;
            ST_MONTH: len = month_secs(month_reg, leap);
            ST_DAY:   len = DAY_SECS;
            ST_HOUR:  len = HOUR_SECS;
            default:  len = MIN_SECS;
        endcase
    end

    es2cd_sub u_sub (
        .rem  (rem_reg),
        .len  (len),
        .diff (diff),
        .ge   (ge)
    );

    always_comb
    begin
        state_next    = state_reg;
        in_range_next = in_range_reg;
        rem_next      = rem_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_YEAR;
                    in_range_next = 1'b1;
                    rem_next      = seconds_count;
                    year_next     = '0;
                    month_next    = MONTH_JAN;
                    day_next      = '0;
                    hour_next     = '0;
                    minute_next   = '0;
                end
            end
            ST_YEAR:
            begin
                if (year_reg >= SPAN)
                begin
                    in_range_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (ge)
                begin
                    rem_next  = diff;
                    year_next = year_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                // December takes whatever is left, so it is never subtracted.
                if (month_reg != MONTH_DEC && ge)
                begin
                    rem_next   = diff;
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (ge)
                begin
                    rem_next = diff;
                    day_next = day_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    hour_next = hour_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (ge)
                begin
                    rem_next    = diff;
                    minute_next = minute_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_range_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_range_reg <= in_range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    always_comb
    begin
        result = '0;
        if (in_range_reg)
        begin
            result.in_range    = 1'b1;
            result.year_offset = 7'(year_reg);
            result.month       = month_reg;
            result.day         = day_reg + 1'b1;
            result.hour        = hour_reg;
            result.minute      = minute_reg;
            result.second      = rem_reg[5:0];
        end
    end

    `ES2CD_ASSERT_NXT(a_start_clears, start && state_reg == ST_IDLE,
        state_reg == ST_YEAR && year_reg == '0 && month_reg == MONTH_JAN,
        "conversion did not start from a cleared state")
    `ES2CD_ASSERT_IMP(a_day_bound, state_reg == ST_DAY, day_reg <= 5'd30,
        "day count ran past the end of the month")
    `ES2CD_ASSERT_NXT(a_min_end, state_reg == ST_MIN && !ge,
        state_reg == ST_DONE && rem_reg < SECS_W'(60),
        "seconds left over after the minute phase")
    `ES2CD_ASSERT_IMP(a_fields_ok, state_reg == ST_DONE && in_range_reg,
        month_reg >= MONTH_JAN && month_reg <= MONTH_DEC && hour_reg <= 5'd23
            && minute_reg <= 6'd59,
        "finished date has a field out of its range")

endmodule

>>> bench/tb_epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_date;
    import es2cd_pkg::*;

    localparam int YEARS = YEAR_SPAN_DEF;
    localparam logic [31:0] FIRST_OUT_OF_RANGE = 32'hBC19_1380;
    localparam int RANDOM_ITEMS = 930;
    localparam int STALL_LIMIT = 20000;
    localparam int DAY_S = 86400;

    typedef struct packed {
        logic [31:0]   secs;
        logic          typed;
        es2cd_result_t want;
    } date_row_t;

    typedef struct packed {
        logic [31:0]   secs;
        es2cd_result_t want;
    } due_date_t;

    localparam es2cd_result_t NOT_IN_RANGE = '0;

    // Rows with typed set carry the result that can be read straight off the calendar;
    // the rest are worked out by the predictor.
    date_row_t directed_rows [22] = '{
        '{32'd0,          1'b1, '{1'b1, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
        '{32'd59,         1'b1, '{1'b1, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd59}},
        '{32'd60,         1'b0, NOT_IN_RANGE},
        '{32'd3599,       1'b0, NOT_IN_RANGE},
        '{32'd3600,       1'b0, NOT_IN_RANGE},
        '{32'd86399,      1'b1, '{1'b1, 7'd0, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
        '{32'd86400,      1'b0, NOT_IN_RANGE},
        '{32'd2678399,    1'b0, NOT_IN_RANGE},
        '{32'd2678400,    1'b0, NOT_IN_RANGE},
        '{32'd5097600,    1'b0, NOT_IN_RANGE},
        '{32'd5184000,    1'b0, NOT_IN_RANGE},
        '{32'd31622399,   1'b0, NOT_IN_RANGE},
        '{32'd31622400,   1'b0, NOT_IN_RANGE},
        '{32'd36719999,   1'b0, NOT_IN_RANGE},
        '{32'd36720000,   1'b0, NOT_IN_RANGE},
        '{32'd131328000,  1'b0, NOT_IN_RANGE},
        '{32'h5555_5555,  1'b0, NOT_IN_RANGE},
        '{32'h7FFF_FFFF,  1'b0, NOT_IN_RANGE},
        '{32'hBC19_137F,  1'b1, '{1'b1, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
        '{32'hBC19_1380,  1'b1, NOT_IN_RANGE},
        '{32'hAAAA_AAAA,  1'b0, NOT_IN_RANGE},
        '{32'hFFFF_FFFF,  1'b1, NOT_IN_RANGE}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    due_date_t     due_dates [$];
    due_date_t     oldest;
    es2cd_result_t seen;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            steady;

    epoch_seconds_to_calendar_date #(
        .YEAR_SPAN(YEARS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit gregorian_leap(input int unsigned off);
        int unsigned y;
        y = 2000 + off;
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned off, input int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return gregorian_leap(off) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic es2cd_result_t calendar_of(input logic [31:0] secs);
        longint unsigned rest;
        longint unsigned span;
        int unsigned     yr;
        int unsigned     mo;
        es2cd_result_t   r;
        rest = secs;
        yr = 0;
        mo = 1;
        span = (gregorian_leap(0) ? 366 : 365) * DAY_S;
        while (yr < YEARS && rest >= span)
        begin
            rest -= span;
            yr++;
            span = (gregorian_leap(yr) ? 366 : 365) * DAY_S;
        end
        if (yr >= YEARS)
            return NOT_IN_RANGE;
        // December is never subtracted: whatever is left belongs to it.
        while (mo < 12 && rest >= longint'(days_in_month(yr, mo)) * DAY_S)
        begin
            rest -= longint'(days_in_month(yr, mo)) * DAY_S;
            mo++;
        end
        r.in_range    = 1'b1;
        r.year_offset = 7'(yr);
        r.month       = 4'(mo);
        r.day         = 5'(rest / DAY_S + 1);
        rest          = rest % DAY_S;
        r.hour        = 5'(rest / 3600);
        rest          = rest % 3600;
        r.minute      = 6'(rest / 60);
        r.second      = 6'(rest % 60);
        return r;
    endfunction

    function automatic logic [31:0] secs_from_date(input int unsigned yr, input int unsigned mo,
                                                   input int unsigned dy, input int unsigned hh,
                                                   input int unsigned mi, input int unsigned ss);
        longint unsigned total;
        total = 0;
        for (int unsigned i = 0; i < yr; i++)
            total += (gregorian_leap(i) ? 366 : 365) * DAY_S;
        for (int unsigned j = 1; j < mo; j++)
            total += longint'(days_in_month(yr, j)) * DAY_S;
        total += longint'(dy - 1) * DAY_S + hh * 3600 + mi * 60 + ss;
        return 32'(total);
    endfunction

    task automatic send_seconds(input logic [31:0] secs, input logic typed,
                                input es2cd_result_t want);
        if (!steady)
        begin
            while ($urandom_range(99) < 38)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        due_dates.push_back('{secs, typed ? want : calendar_of(secs)});
    endtask

    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_dates.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            m_axis_tready <= steady || ($urandom_range(99) >= 38);
            @(posedge clk);
        end
    end

    // Result checker: every accepted item is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.in_range    = m_axis_tuser;
            seen.year_offset = m_axis_tdata[6:0];
            seen.month       = m_axis_tdata[10:7];
            seen.day         = m_axis_tdata[15:11];
            seen.hour        = m_axis_tdata[20:16];
            seen.minute      = m_axis_tdata[26:21];
            seen.second      = m_axis_tdata[32:27];
            if (due_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result in=%0d %0d-%0d-%0d %0d:%0d:%0d",
                             seen.in_range, seen.year_offset, seen.month, seen.day,
                             seen.hour, seen.minute, seen.second);
            end
            else
            begin
                oldest = due_dates.pop_front();
                if (seen !== oldest.want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"secs %h: want in=%0d %0d-%0d-%0d %0d:%0d:%0d,",
                                  " got in=%0d %0d-%0d-%0d %0d:%0d:%0d"},
                                 oldest.secs, oldest.want.in_range, oldest.want.year_offset,
                                 oldest.want.month, oldest.want.day, oldest.want.hour,
                                 oldest.want.minute, oldest.want.second, seen.in_range,
                                 seen.year_offset, seen.month, seen.day, seen.hour,
                                 seen.minute, seen.second);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int unsigned   pick;
        int unsigned   yr;
        int unsigned   mo;
        int unsigned   dy;
        logic [31:0]   secs;
        steady        = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_seconds(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 300 && n < 500);
            if (n == 600)
                wait_for_results();
            pick = $urandom_range(99);
            yr   = $urandom_range(YEARS - 1);
            mo   = $urandom_range(12, 1);
            if (pick < 45)
            begin
                // Month ends and the last seconds of the day are favoured.
                dy = $urandom_range(1) ? days_in_month(yr, mo)
                                       : $urandom_range(days_in_month(yr, mo), 1);
                secs = secs_from_date(yr, mo, dy,
                                      ($urandom_range(3) == 0) ? 23 : $urandom_range(23),
                                      ($urandom_range(3) == 0) ? 59 : $urandom_range(59),
                                      ($urandom_range(3) == 0) ? 59 : $urandom_range(59));
            end
            else if (pick < 70)
                secs = $urandom_range(FIRST_OUT_OF_RANGE - 1, 0);
            else if (pick < 85)
            begin
                // A couple of seconds either side of a month or year start, up to the limit.
                if ($urandom_range(9) == 0)
                    secs = FIRST_OUT_OF_RANGE;
                else
                    secs = secs_from_date(yr, mo, 1, 0, 0, 0);
                secs = secs + $urandom_range(4) - 2;
            end
            else
                secs = $urandom();
            send_seconds(secs, 1'b0, NOT_IN_RANGE);
        end
        steady = 1'b0;
        wait_for_results();
        repeat (300) @(posedge clk);

        if (mismatches == 0 && due_dates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
